// File: sv/sci_pkg.sv
// Package for the sensor calibration interpolator.
// It holds the item types, command, mode and status codes and register indexes.
// It has no dependencies.
`timescale 1ns / 1ps
package sci_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_CORRECT = 2'd0;
    localparam logic [1:0] CMD_INSERT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    // Correction modes.
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_TABLE  = 2'd1;
    localparam logic [1:0] MODE_QUAD   = 2'd2;

    // Status codes of a result item.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SAT      = 3'd1;
    localparam logic [2:0] ST_FEW      = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_COEF0   = 2'd1;
    localparam logic [1:0] REG_COEF1   = 2'd2;
    localparam logic [1:0] REG_COEF2   = 2'd3;

    typedef struct packed {
        logic        [1:0]  command;
        logic signed [31:0] raw_value;
        logic signed [31:0] true_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] corrected;
        logic        [2:0]  status;
    } t_out_item;

    // Divider handshake between the sequencer and the shared divide unit.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

endpackage

// File: sv/sci_ram.sv
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module sci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sci_div.sv
// Shared restoring divider, one quotient bit per cycle, 64 by 33 bits.
// Depends on sci_pkg.
`timescale 1ns / 1ps
module sci_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sci_pkg::t_div_req i_req,
    output sci_pkg::t_div_rsp o_rsp
);
    import sci_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [32:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_done;
    logic [33:0] w_sh;

    // One shift and trial subtract per cycle.
    always_comb begin
        w_sh  = {r_rem, r_quo[63]};
        n_quo = {r_quo[62:0], 1'b0};
        n_rem = w_sh[32:0];
        if (w_sh >= {1'b0, r_den}) begin
            n_rem    = 33'(w_sh - {1'b0, r_den});
            n_quo[0] = 1'b1;
        end
        n_cnt = r_cnt - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= n_cnt;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // The quotient is reported only once the busy phase ends.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 7'd1 && !i_req.start) |=> r_done)
        else $error("divider missed its done pulse");

endmodule

// File: sv/sensor_calibration_interpolator_unit.sv
// Sensor calibration interpolator: passthrough, quadratic or table correction.
// Channels: input items (command, raw, true) and result items (corrected, status),
// each a valid/stall pair; registers are written through a plain write port.
// Depends on sci_pkg, sci_ram and sci_div.
//
// One item is worked on at a time; an item is accepted only while the sequencer
// is idle. A finished item waits in the sequencer until the result register is free.
// Passthrough, clear and the unused command go straight to the result; quadratic
// steps through the shared multiplier; an insert with N stored points scans for
// duplicates and shifts the upper entries, one table access per cycle on the single
// RAM port; an interpolation runs a binary search and then waits for the 64-step
// shared divider that produces one quotient bit per cycle.
// Reset (synchronous, active low) empties the table, restores the register
// defaults and clears the result valid flag; table contents stay undefined.
// While the receiver stalls, the result item holds and the next finished item waits.
`timescale 1ns / 1ps
module sensor_calibration_interpolator_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sci_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sci_pkg::t_out_item  o_out_item
);
    import sci_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SRCH  = 12'b000000000010,
        S_SWAIT = 12'b000000000100,
        S_RDA   = 12'b000000001000,
        S_RDB   = 12'b000000010000,
        S_RDC   = 12'b000000100000,
        S_DIV   = 12'b000001000000,
        S_QUAD  = 12'b000010000000,
        S_SCAN  = 12'b000100000000,
        S_SHIFT = 12'b001000000000,
        S_SHWR  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [1:0]         r_mode;
    logic signed [31:0] r_c0, r_c1, r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_c0   <= '0;
            r_c1   <= 32'sd65536;
            r_c2   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:  r_mode <= i_cfg_data[1:0];
                REG_COEF0: r_c0   <= i_cfg_data;
                REG_COEF1: r_c1   <= i_cfg_data;
                REG_COEF2: r_c2   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Table storage: one RAM per coordinate, sharing address control.
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wraw, w_wtru, w_rraw, w_rtru;

    sci_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_raw (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wraw),
        .i_raddr(w_raddr), .o_rdata(w_rraw)
    );
    sci_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_tru (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wtru),
        .i_raddr(w_raddr), .o_rdata(w_rtru)
    );

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    sci_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // Working registers.
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_lo, r_hi, r_idx, r_pos;
    logic signed [31:0] r_x, r_y;
    logic signed [31:0] r_x1, r_y1, r_x2;
    logic               r_neg;
    logic signed [65:0] r_acc;
    logic [2:0]         r_qstep;
    logic signed [63:0] r_prod;
    logic [2:0]         r_st;
    logic signed [31:0] r_res;
    logic               r_ovalid;
    t_out_item          r_out;
    logic               r_found;
    logic               r_sat_en;
    logic               r_dstart;

    logic w_accept;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Shared 33x33 signed multiplier, fed by the quadratic sequencer.
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    logic signed [32:0] w_sqh;
    always_comb begin
        w_sqh = $signed({1'b0, r_prod[63:32]});
        unique case (r_qstep)
            3'd0:    begin w_ma = 33'(r_c1); w_mb = 33'(r_x); end
            3'd1:    begin w_ma = 33'(r_x);  w_mb = 33'(r_x); end
            3'd2:    begin w_ma = 33'(r_c2); w_mb = w_sqh;    end
            3'd3:    begin w_ma = 33'(r_c2); w_mb = $signed({17'd0, r_prod[31:16]}); end
            default: begin w_ma = '0;        w_mb = '0;       end
        endcase
        w_mp = w_ma * w_mb;
    end

    // Interpolation operands.
    logic signed [32:0] w_dy, w_t, w_dx;
    logic [32:0]        w_ady, w_at;
    logic signed [65:0] w_q, w_ires;
    always_comb begin
        w_dy  = 33'($signed(w_rtru)) - 33'(r_y1);
        w_t   = 33'(r_x) - 33'(r_x1);
        w_dx  = 33'(r_x2) - 33'(r_x1);
        w_ady = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
        w_at  = w_t[32]  ? 33'(-w_t)  : 33'(w_t);
        w_q   = (w_drsp.quotient > 64'h100_0000_0000) ? 66'sh100_0000_0000
                                                      : $signed({2'b00, w_drsp.quotient});
        w_ires = r_neg ? 66'(r_y1) - w_q : 66'(r_y1) + w_q;
    end

    logic [63:0] r_dmul;
    assign w_dreq.start    = r_dstart;
    assign w_dreq.dividend = r_dmul;
    assign w_dreq.divisor  = 33'(w_dx);

    // Read address and write control.
    logic [CW-1:0] w_mid;
    assign w_mid = CW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);

    always_comb begin
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wraw  = w_rraw;
        w_wtru  = w_rtru;
        unique case (r_state)
            S_SRCH, S_SWAIT: w_raddr = w_mid[AW-1:0];
            S_RDA:           w_raddr = r_lo[AW-1:0];
            S_RDB:           w_raddr = r_hi[AW-1:0];
            S_RDC:           w_raddr = r_hi[AW-1:0];
            S_SCAN:          w_raddr = r_idx[AW-1:0];
            S_SHIFT:         w_raddr = AW'(r_idx - 1'b1);
            S_SHWR: begin
                w_we = 1'b1;
                if (r_idx == r_pos) begin
                    w_wraw = r_x;
                    w_wtru = r_y;
                end
            end
            default: ;
        endcase
    end

    logic [31:0] r_first, r_last;   // raw of first and last points, cached
    logic signed [65:0] w_sat_in;
    always_comb w_sat_in = r_acc;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_dstart  <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (r_ovalid && !i_out_stall && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_x   <= i_in_item.raw_value;
                    r_y   <= i_in_item.true_value;
                    r_st  <= ST_OK;
                    r_res <= '0;
                    r_sat_en <= 1'b0;
                    r_state <= S_DONE;
                    unique case (i_in_item.command)
                        CMD_CORRECT: begin
                            r_res <= i_in_item.raw_value;
                            if (r_mode == MODE_TABLE) begin
                                if (r_cnt < CW'(2)) r_st <= ST_FEW;
                                else if (i_in_item.raw_value < $signed(r_first)) begin
                                    r_lo <= '0; r_hi <= CW'(1); r_state <= S_RDA;
                                end else if (i_in_item.raw_value > $signed(r_last)) begin
                                    r_lo <= CW'(r_cnt - 2'd2); r_hi <= CW'(r_cnt - 1'b1);
                                    r_state <= S_RDA;
                                end else begin
                                    r_lo <= '0; r_hi <= CW'(r_cnt - 1'b1);
                                    r_state <= S_SRCH;
                                end
                            end else if (r_mode == MODE_QUAD) begin
                                r_qstep <= 3'd0;
                                r_acc   <= 66'(r_c0);
                                r_state <= S_QUAD;
                            end
                        end
                        CMD_INSERT: begin
                            r_idx   <= '0;
                            r_pos   <= r_cnt;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end
                        CMD_CLEAR: r_cnt <= '0;
                        default: ;
                    endcase
                end
                // Binary search: issue read of mid, then compare.
                S_SRCH: begin
                    if (r_hi - r_lo > CW'(1)) r_state <= S_SWAIT;
                    else r_state <= S_RDA;
                end
                S_SWAIT: begin
                    if (r_x < $signed(w_rraw)) r_hi <= w_mid; else r_lo <= w_mid;
                    r_state <= S_SRCH;
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_x1 <= w_rraw;
                    r_y1 <= w_rtru;
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_x2   <= w_rraw;
                    r_neg  <= 1'b0;
                    r_state <= S_DIV;
                    r_qstep <= 3'd7;
                end
                S_DIV: begin
                    // With r_qstep at 7 it forms |dy|*|t|; at 6 it starts the divider; then it waits for done.
                    if (r_qstep == 3'd7) begin
                        r_neg   <= w_dy[32] != w_t[32];
                        r_dmul  <= 64'({31'd0, w_ady} * {31'd0, w_at});
                        r_qstep <= 3'd6;
                    end else if (r_qstep == 3'd6) begin
                        r_dstart <= 1'b1;
                        r_qstep <= 3'd5;
                    end else if (w_drsp.done) begin
                        r_acc    <= w_ires;
                        r_sat_en <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                // Quadratic: multiply, register, accumulate.
                S_QUAD: begin
                    unique case (r_qstep)
                        3'd0: begin r_acc <= r_acc + (w_mp >>> 16); r_qstep <= 3'd1; end
                        3'd1: begin r_prod <= 64'(w_mp); r_qstep <= 3'd2; end
                        3'd2: begin r_acc <= r_acc + w_mp; r_qstep <= 3'd3; end
                        3'd3: begin
                            r_acc <= r_acc + (w_mp >>> 16);
                            r_sat_en <= 1'b1;
                            r_state  <= S_DONE;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                // Duplicate scan and insertion position; the registered read data belongs to the previous index.
                S_SCAN: begin
                    if (r_idx != '0) begin
                        if ($signed(w_rraw) == r_x) r_found <= 1'b1;
                        if ($signed(w_rraw) > r_x && r_pos == r_cnt)
                            r_pos <= CW'(r_idx - 1'b1);
                    end
                    if (r_idx == r_cnt) begin
                        if (r_found || (r_idx != '0 && $signed(w_rraw) == r_x)) begin
                            r_st <= ST_DUP; r_state <= S_DONE;
                        end else if (r_cnt >= CW'(MAX_POINTS)) begin
                            r_st <= ST_FULL; r_state <= S_DONE;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end else r_idx <= CW'(r_idx + 1'b1);
                end
                S_SHIFT: r_state <= S_SHWR;
                S_SHWR: begin
                    if (r_idx == r_pos) begin
                        r_cnt   <= CW'(r_cnt + 1'b1);
                        if (r_pos == '0) r_first <= r_x;
                        if (r_pos == r_cnt) r_last <= r_x;
                        r_state <= S_DONE;
                    end else begin
                        if (r_idx == r_cnt) r_last <= w_rraw;
                        r_idx   <= CW'(r_idx - 1'b1);
                        r_state <= S_SHIFT;
                    end
                end
                // Load the result register once it is free.
                S_DONE: if (!r_ovalid || !i_out_stall) begin
                    r_out.corrected <= r_res;
                    r_out.status    <= r_st;
                    if (r_sat_en) begin
                        if (w_sat_in > 66'sd2147483647) begin
                            r_out.corrected <= 32'sh7fffffff; r_out.status <= ST_SAT;
                        end else if (w_sat_in < -66'sd2147483648) begin
                            r_out.corrected <= 32'sh80000000; r_out.status <= ST_SAT;
                        end else begin
                            r_out.corrected <= w_sat_in[31:0];
                        end
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // No item is taken while work is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("item accepted without leaving idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count beyond table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |=> r_ovalid && $stable(r_out))
        else $error("stalled result changed");

endmodule
